// ----- design/lpg_pkg.sv -----
// Shared types and constants for the line point generator.
package lpg_pkg;

    localparam int COORD_W    = 6;
    localparam int DIV_STEPS  = COORD_W;
    localparam int DIV_CNT_W  = 3;

    typedef struct packed {
        logic [COORD_W-1:0] x_start;
        logic [COORD_W-1:0] y_start;
        logic [COORD_W-1:0] x_end;
        logic [COORD_W-1:0] y_end;
    } t_in;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic               last_pixel;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic div_fix;
        logic advance;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic degen;
        logic last;
    } t_sts;

endpackage

// ----- design/lpg_dp.sv -----
// Datapath: line setup, restoring slope divider and per-column stepper.
module lpg_dp #(
    parameter int CNT_W = 6,
    parameter int GRID_SIZE = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lpg_pkg::t_in  i_in_data,
    input  lpg_pkg::t_cmd i_cmd,
    output lpg_pkg::t_sts o_sts,
    output lpg_pkg::t_out o_out_data
);

    localparam int W = lpg_pkg::COORD_W;

    logic [W-1:0]     r_cur_x, r_cur_y, r_end_x, r_dx, r_rem;
    logic [W-1:0]     r_q, r_r;
    logic [W-1:0]     r_num, r_div_rem;
    logic             r_dy_neg;
    logic [CNT_W-1:0] r_cnt;

    logic             degen;
    logic [W:0]       dy;
    logic [W-1:0]     dy_abs;
    logic [W:0]       partial;
    logic             part_ge;
    logic [W:0]       step_sum;
    logic             step_wrap;
    logic             last;

    assign degen   = (i_in_data.x_end <= i_in_data.x_start);
    assign dy      = {1'b0, i_in_data.y_end} - {1'b0, i_in_data.y_start};
    assign dy_abs  = dy[W] ? W'(~dy + 1'b1) : dy[W-1:0];

    assign partial = {r_div_rem, r_num[W-1]};
    assign part_ge = (partial >= {1'b0, r_dx});

    assign step_sum  = {1'b0, r_rem} + {1'b0, r_r};
    assign step_wrap = (step_sum >= {1'b0, r_dx});

    assign last = (r_cur_x == r_end_x) || (r_cnt == CNT_W'(GRID_SIZE - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur_x   <= i_in_data.x_start;
            r_cur_y   <= i_in_data.y_start;
            r_end_x   <= degen ? i_in_data.x_start : i_in_data.x_end;
            r_dx      <= i_in_data.x_end - i_in_data.x_start;
            r_dy_neg  <= dy[W];
            r_num     <= dy_abs;
            r_div_rem <= '0;
            r_rem     <= '0;
            r_cnt     <= '0;
        end else if (i_cmd.div_step) begin
            if (part_ge) begin
                r_div_rem <= W'(partial - {1'b0, r_dx});
                r_num     <= {r_num[W-2:0], 1'b1};
            end else begin
                r_div_rem <= partial[W-1:0];
                r_num     <= {r_num[W-2:0], 1'b0};
            end
        end else if (i_cmd.div_fix) begin
            // floor division with remainder kept in 0..dx-1
            if (!r_dy_neg) begin
                r_q <= r_num;
                r_r <= r_div_rem;
            end else if (r_div_rem == '0) begin
                r_q <= ~r_num + 1'b1;
                r_r <= '0;
            end else begin
                r_q <= ~r_num;
                r_r <= r_dx - r_div_rem;
            end
        end else if (i_cmd.advance) begin
            r_cur_x <= r_cur_x + 1'b1;
            r_cnt   <= r_cnt + 1'b1;
            if (step_wrap) begin
                r_rem   <= W'(step_sum - {1'b0, r_dx});
                r_cur_y <= r_cur_y + r_q + 1'b1;
            end else begin
                r_rem   <= step_sum[W-1:0];
                r_cur_y <= r_cur_y + r_q;
            end
        end
    end

    assign o_sts.degen = degen;
    assign o_sts.last  = last;

    assign o_out_data.pixel_x    = r_cur_x;
    assign o_out_data.pixel_y    = r_cur_y;
    assign o_out_data.last_pixel = last;

    a_step_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.advance |=> r_cur_x == $past(r_cur_x) + 1'b1)
        else $error("column did not advance by one");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.advance |-> (r_rem < r_dx) && (r_r < r_dx))
        else $error("remainder out of range");

    a_not_last_on_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.advance |-> !last)
        else $error("stepped past the final pixel");

endmodule

// ----- design/lpg_ctrl.sv -----
// Controller: sequences setup, slope division and pixel emission.
module lpg_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_ready,
    input  lpg_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output lpg_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIX,
        S_EMIT
    } t_state;

    t_state                        r_state;
    logic                          r_in_ready;
    logic                          r_out_valid;
    logic [lpg_pkg::DIV_CNT_W-1:0] r_div_cnt;

    logic in_acc;
    logic out_acc;

    assign in_acc  = i_in_valid && r_in_ready;
    assign out_acc = r_out_valid && i_out_ready;

    assign o_cmd.load     = in_acc;
    assign o_cmd.div_step = (r_state == S_DIV);
    assign o_cmd.div_fix  = (r_state == S_FIX);
    assign o_cmd.advance  = (r_state == S_EMIT) && out_acc && !i_sts.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b0;
            r_out_valid <= 1'b0;
            r_div_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_in_ready <= 1'b0;
                        r_div_cnt  <= '0;
                        if (i_sts.degen) begin
                            r_state     <= S_EMIT;
                            r_out_valid <= 1'b1;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end else begin
                        r_in_ready <= 1'b1;
                    end
                end
                S_DIV: begin
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (r_div_cnt == lpg_pkg::DIV_CNT_W'(lpg_pkg::DIV_STEPS - 1)) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    r_state     <= S_EMIT;
                    r_out_valid <= 1'b1;
                end
                S_EMIT: begin
                    if (out_acc && i_sts.last) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b0;
                        r_in_ready  <= 1'b1;
                    end
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b0;
                    r_in_ready  <= 1'b0;
                end
            endcase
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_out_valid && r_in_ready))
        else $error("input and output open together");

    a_back_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_acc && i_sts.last) |=> r_in_ready && !r_out_valid)
        else $error("not ready after final pixel");

    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_div_cnt < lpg_pkg::DIV_CNT_W'(lpg_pkg::DIV_STEPS)))
        else $error("divider ran too long");

    a_valid_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == S_EMIT))
        else $error("output valid outside emit");

endmodule

// ----- design/line_point_generator_core.sv -----
// Top level of the line point generator: controller plus datapath.
//
//  channel | dir | handshake                | payload
//  in      | in  | i_in_valid / o_in_ready  | i_in_data  (x_start, y_start, x_end, y_end)
//  out     | out | o_out_valid / i_out_ready| o_out_data (pixel_x, pixel_y, last_pixel)
//
// One line at a time. After a request transaction with x_end > x_start, the slope dy/dx is split
// into quotient and remainder by a restoring divider (divide steps, then a fixup); then one pixel
// per cycle is offered while the output is not stalled: dx+1 pixels (capped at GRID_SIZE),
// 1 when x_end <= x_start, in which case the divider is skipped.
// Output stalls hold the current pixel; no new request is taken until the last pixel leaves.
// Synchronous active-low reset returns to idle with the input not ready; idle then raises it.
module line_point_generator_core #(
    parameter int GRID_SIZE = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lpg_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output lpg_pkg::t_out o_out_data
);

    localparam int CNT_W = $clog2(GRID_SIZE);

    lpg_pkg::t_cmd cmd;
    lpg_pkg::t_sts sts;

    lpg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    lpg_dp #(
        .CNT_W     (CNT_W),
        .GRID_SIZE (GRID_SIZE)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

endmodule
